// File: src/wsenc_pkg.sv
// Shared types and constants for the client frame encoder.
// Holds the request and response transaction structs and the header codes.
// No dependencies.
package wsenc_pkg;

   typedef struct packed {
      logic        start_frame;
      logic        final_fragment;
      logic [62:0] payload_length;
      logic [31:0] mask_key;
      logic        has_byte;
      logic [7:0]  payload_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_header;
      logic       frame_end;
   } rsp_type;

   // One wire byte handed from the sequencer to the output register.
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } wsenc_push_type;

   localparam logic [7:0]  FIN_BIT   = 8'h80;
   localparam logic [7:0]  OPC_TEXT  = 8'h01;
   localparam logic [7:0]  MASK_BIT  = 8'h80;
   localparam logic [62:0] SHORT_MAX = 63'd125;
   localparam logic [62:0] MID_MAX   = 63'hFFFF;
   localparam logic [7:0]  CODE16    = 8'd126;
   localparam logic [7:0]  CODE64    = 8'd127;

   // Header lengths in bytes for the three length encodings.
   localparam logic [3:0]  HDR_SHORT = 4'd6;
   localparam logic [3:0]  HDR_MID   = 4'd8;
   localparam logic [3:0]  HDR_LONG  = 4'd14;

   // Position of the first mask key byte for each encoding.
   localparam logic [3:0]  KEY_SHORT = 4'd2;
   localparam logic [3:0]  KEY_MID   = 4'd4;
   localparam logic [3:0]  KEY_LONG  = 4'd10;

endpackage

// File: src/wsenc_hdr_mux.sv
// Header byte selection for one frame start transaction.
// Picks the header, length or mask byte at a given position and reports the header length.
// Depends on wsenc_pkg.
module wsenc_hdr_mux import wsenc_pkg::*; (
   input  req_type    item,
   input  logic [3:0] step,
   output logic [7:0] hdr_byte,
   output logic [3:0] hdr_count,
   output logic       hdr_end
);

   logic        is_short;
   logic        is_mid;
   logic [63:0] len64;
   logic [3:0]  key_base;
   logic [1:0]  key_idx;
   logic [2:0]  len_idx;
   logic [7:0]  key_byte;
   logic [7:0]  long_byte;
   logic [7:0]  code_byte;

   always_comb begin
      is_short  = item.payload_length <= SHORT_MAX;
      is_mid    = !is_short && (item.payload_length <= MID_MAX);
      len64     = {1'b0, item.payload_length};

      if (is_short) begin
         key_base  = KEY_SHORT;
         hdr_count = HDR_SHORT;
         code_byte = MASK_BIT | {1'b0, item.payload_length[6:0]};
      end else if (is_mid) begin
         key_base  = KEY_MID;
         hdr_count = HDR_MID;
         code_byte = MASK_BIT | CODE16;
      end else begin
         key_base  = KEY_LONG;
         hdr_count = HDR_LONG;
         code_byte = MASK_BIT | CODE64;
      end

      key_idx  = 2'(step - key_base);
      key_byte = 8'(item.mask_key >> {key_idx, 3'b000});

      // The 64-bit length goes out most significant byte first.
      len_idx   = 3'(step - 4'd2);
      long_byte = 8'(len64 >> {~len_idx, 3'b000});

      if (step == 4'd0) begin
         hdr_byte = OPC_TEXT | (item.final_fragment ? FIN_BIT : 8'h00);
      end else if (step == 4'd1) begin
         hdr_byte = code_byte;
      end else if (step >= key_base) begin
         hdr_byte = key_byte;
      end else if (is_mid) begin
         hdr_byte = (step == 4'd2) ? item.payload_length[15:8] : item.payload_length[7:0];
      end else begin
         hdr_byte = long_byte;
      end

      // An empty frame ends on its last mask byte.
      hdr_end = (item.payload_length == 63'd0) && (step == HDR_SHORT - 4'd1);
   end

endmodule

// File: src/wsenc_frame_seq.sv
// Frame sequencer: holds one request transaction, walks its wire bytes and keeps frame state.
// Hands one byte per cycle to the output register when it has room.
// Depends on wsenc_pkg and wsenc_hdr_mux.
module wsenc_frame_seq import wsenc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  req_type        req_data,
   input  logic           out_ready,
   output wsenc_push_type push
);

   logic        item_valid_ff, item_valid_in;
   req_type     item_ff;
   logic [3:0]  step_ff, step_in;
   logic [62:0] bytes_left_ff, bytes_left_in;
   logic [31:0] mask_store_ff, mask_store_in;
   logic [1:0]  mask_phase_ff, mask_phase_in;

   logic [7:0]  hdr_byte;
   logic [3:0]  hdr_count;
   logic        hdr_end;

   logic [62:0] eff_left;
   logic [31:0] eff_key;
   logic [1:0]  eff_phase;
   logic        emit;
   logic [3:0]  hdr_len;
   logic [3:0]  result_count;
   logic        in_payload;
   logic [7:0]  mask_byte;
   logic        push_fire;
   logic        item_done;

   wsenc_hdr_mux u_hdr_mux (
      .item      (item_ff),
      .step      (step_ff),
      .hdr_byte  (hdr_byte),
      .hdr_count (hdr_count),
      .hdr_end   (hdr_end)
   );

   always_comb begin
      // A frame start replaces the stored frame state before its own payload byte.
      eff_left  = item_ff.start_frame ? item_ff.payload_length : bytes_left_ff;
      eff_key   = item_ff.start_frame ? item_ff.mask_key : mask_store_ff;
      eff_phase = item_ff.start_frame ? 2'd0 : mask_phase_ff;
      emit      = item_ff.has_byte && (eff_left != 63'd0);

      hdr_len      = item_ff.start_frame ? hdr_count : 4'd0;
      result_count = hdr_len + {3'd0, emit};
      in_payload   = (step_ff == hdr_len);
      mask_byte    = 8'(eff_key >> {eff_phase, 3'b000});

      push_fire = item_valid_ff && (result_count != 4'd0) && out_ready;
      if (result_count == 4'd0) begin
         item_done = item_valid_ff;
      end else begin
         item_done = push_fire && (step_ff == result_count - 4'd1);
      end

      push.valid = push_fire;
      if (in_payload) begin
         push.data.out_byte  = item_ff.payload_byte ^ mask_byte;
         push.data.is_header = 1'b0;
         push.data.frame_end = (eff_left == 63'd1);
      end else begin
         push.data.out_byte  = hdr_byte;
         push.data.is_header = 1'b1;
         push.data.frame_end = hdr_end;
      end

      req_stall     = item_valid_ff && !item_done;
      item_valid_in = req_stall ? item_valid_ff : req_valid;

      if (item_done) begin
         step_in = 4'd0;
      end else if (push_fire) begin
         step_in = step_ff + 4'd1;
      end else begin
         step_in = step_ff;
      end

      bytes_left_in = bytes_left_ff;
      mask_store_in = mask_store_ff;
      mask_phase_in = mask_phase_ff;
      if (item_done) begin
         bytes_left_in = emit ? eff_left - 63'd1 : eff_left;
         mask_store_in = eff_key;
         mask_phase_in = emit ? eff_phase + 2'd1 : eff_phase;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         step_ff       <= 4'd0;
         bytes_left_ff <= 63'd0;
         mask_store_ff <= 32'd0;
         mask_phase_ff <= 2'd0;
      end else begin
         item_valid_ff <= item_valid_in;
         step_ff       <= step_in;
         bytes_left_ff <= bytes_left_in;
         mask_store_ff <= mask_store_in;
         mask_phase_ff <= mask_phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_data;
      end
   end

   // The byte counter stays inside the result list of the held transaction.
   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      push_fire |-> (step_ff < result_count))
      else $error("sequencer step past the last wire byte");

   // With no transaction held the byte counter rests at zero.
   a_step_idle: assert property (@(posedge clock) disable iff (reset)
      !item_valid_ff |-> (step_ff == 4'd0))
      else $error("sequencer step not cleared while idle");

   // A byte is only handed over when the output register can take it.
   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> out_ready)
      else $error("byte pushed into a full output register");

   // After the byte marked as frame end, no payload bytes remain expected.
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (push_fire && in_payload && push.data.frame_end) |=> (bytes_left_ff == 63'd0))
      else $error("frame end sent with payload bytes still expected");

endmodule

// File: src/wsenc_out_reg.sv
// Output register for the response channel.
// Holds one wire byte until the receiver takes it; tells the sequencer when it has room.
// Depends on wsenc_pkg.
module wsenc_out_reg import wsenc_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  wsenc_push_type push,
   output logic           out_ready,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_type        rsp_data
);

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   always_comb begin
      out_ready = !rsp_valid_ff || !rsp_stall;
      if (push.valid) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         rsp_data_ff <= push.data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: src/websocket_client_frame_encoder_core.sv
// Masked client text frame encoder. Each request transaction either opens a frame
// (start_frame set: FIN flag, 63-bit payload length and 32-bit mask key) or carries one
// payload byte, or both. Every wire byte comes out as its own response transaction with
// is_header and frame_end flags. A payload byte passes the request register, then the
// output register; a byte stream passes at one byte per cycle while rsp_stall is low. A
// frame start emits 6, 8 or 14 wire bytes for the short, 16-bit and 64-bit length headers,
// plus one if it carries a payload byte; the output register moves one wire byte per cycle
// while rsp_stall is low, and req_stall is high while they drain. Payload bytes beyond the
// declared length produce no response. A new frame start drops the rest of an open frame.
// Depends on wsenc_pkg, wsenc_frame_seq and wsenc_out_reg.
module websocket_client_frame_encoder_core import wsenc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   wsenc_push_type push;
   logic           out_ready;

   wsenc_frame_seq u_frame_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .out_ready (out_ready),
      .push      (push)
   );

   wsenc_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_ready (out_ready),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
